// ===== rtl/core/b64d_pkg.sv =====
// shared types, constants and the alphabet lookup for the base64 stream decoder
`timescale 1ns / 1ps

package b64d_pkg;

  localparam int unsigned CharW      = 8;
  localparam int unsigned SextetW    = 6;
  localparam int unsigned AccW       = 24;
  localparam int unsigned PadW       = 3;
  localparam int unsigned LineW      = 16;
  localparam int unsigned ByteCntW   = 24;
  localparam int unsigned OutDataW   = 56;
  localparam int unsigned FifoDepth  = 4;
  localparam int unsigned FifoPtrW   = $clog2(FifoDepth);
  localparam int unsigned FifoCntW   = $clog2(FifoDepth + 1);

  localparam logic [CharW-1:0] ChSpace   = 8'h20;
  localparam logic [CharW-1:0] ChTab     = 8'h09;
  localparam logic [CharW-1:0] ChNewline = 8'h0A;
  localparam logic [CharW-1:0] ChPad     = 8'h3D;

  localparam logic [LineW-1:0]    LineMax = '1;
  localparam logic [ByteCntW-1:0] ByteMax = '1;
  localparam logic [PadW-1:0]     PadMax  = '1;

  // result kinds
  localparam logic KindData    = 1'b0;
  localparam logic KindSummary = 1'b1;

  // work handed from front to back: up to three bytes and maybe a summary
  typedef struct packed {
    logic [AccW-1:0]  bytes;
    logic [1:0]       count;
    logic             eod;
    logic             err;
    logic [LineW-1:0] lines;
  } job_t;

  typedef struct packed {
    logic [SextetW-1:0] value;
    logic               ok;
  } sextet_t;

  // standard alphabet: A-Z a-z 0-9 + /
  function automatic sextet_t map_char(input logic [CharW-1:0] c);
    sextet_t r;
    r.ok    = 1'b1;
    r.value = '0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r.value = SextetW'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      r.value = SextetW'(c - 8'h61 + 8'd26);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      r.value = SextetW'(c - 8'h30 + 8'd52);
    end else if (c == 8'h2B) begin
      r.value = SextetW'(62);
    end else if (c == 8'h2F) begin
      r.value = SextetW'(63);
    end else begin
      r.ok = 1'b0;
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/b64d_front.sv =====
// front end: takes characters, collects sextets into quads and hands out jobs
`timescale 1ns / 1ps

module b64d_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic [b64d_pkg::CharW-1:0] in_char,
  input  logic                  in_eod,
  output logic                  in_ready,
  input  logic                  q_full,
  output logic                  push,
  output b64d_pkg::job_t        push_job
);
  import b64d_pkg::*;

  logic [AccW-1:0]  acc, acc_next;
  logic [1:0]       pos, pos_next;
  logic [PadW-1:0]  pads, pads_next;
  logic             err, err_next;
  logic [LineW-1:0] lines, lines_next;
  logic             quad_done;
  logic             take;
  sextet_t          sx;
  logic [SextetW-1:0] v;

  assign in_ready = !q_full;
  assign take     = in_valid && in_ready;

  always_comb begin
    acc_next   = acc;
    pos_next   = pos;
    pads_next  = pads;
    err_next   = err;
    lines_next = lines;
    quad_done  = 1'b0;
    sx         = map_char(in_char);
    v          = '0;
    if (in_char == ChSpace || in_char == ChTab) begin
      // skipped
    end else if (in_char == ChNewline) begin
      if (lines != LineMax) lines_next = lines + 1'b1;
    end else begin
      if (in_char == ChPad) begin
        if (pads != PadMax) pads_next = pads + 1'b1;
      end else if (sx.ok) begin
        v = sx.value;
      end else begin
        err_next = 1'b1;
      end
      acc_next  = {acc[AccW-SextetW-1:0], v};
      pos_next  = pos + 1'b1;
      quad_done = (pos == 2'd3);
    end
  end

  always_comb begin
    push_job.bytes = acc_next;
    push_job.eod   = in_eod;
    push_job.err   = err_next;
    push_job.lines = lines_next;
    if (!quad_done)            push_job.count = 2'd0;
    else if (pads_next == 3'd1) push_job.count = 2'd2;
    else if (pads_next == 3'd2) push_job.count = 2'd1;
    else                        push_job.count = 2'd3;
    push = take && (quad_done || in_eod);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc   <= '0;
      pos   <= '0;
      pads  <= '0;
      err   <= 1'b0;
      lines <= '0;
    end else if (take) begin
      if (in_eod) begin
        acc   <= '0;
        pos   <= '0;
        pads  <= '0;
        err   <= 1'b0;
        lines <= '0;
      end else if (quad_done) begin
        acc   <= '0;
        pos   <= '0;
        pads  <= '0;
        err   <= err_next;
        lines <= lines_next;
      end else begin
        acc   <= acc_next;
        pos   <= pos_next;
        pads  <= pads_next;
        err   <= err_next;
        lines <= lines_next;
      end
    end
  end

endmodule

// ===== rtl/core/b64d_fifo.sv =====
// short job queue between front and back
`timescale 1ns / 1ps

module b64d_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  b64d_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output b64d_pkg::job_t head_job
);
  import b64d_pkg::*;

  job_t                mem [FifoDepth];
  logic [FifoPtrW-1:0] wr_ptr, rd_ptr;
  logic [FifoCntW-1:0] fill;
  logic                do_push, do_pop;

  assign full       = (fill == FifoCntW'(FifoDepth));
  assign head_valid = (fill != '0);
  assign head_job   = mem[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({do_push, do_pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

// ===== rtl/core/b64d_back.sv =====
// back end: expands jobs into byte and summary beats behind an output register
`timescale 1ns / 1ps

module b64d_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        head_valid,
  input  b64d_pkg::job_t              head_job,
  output logic                        pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_kind,
  output logic                        out_last,
  output logic [b64d_pkg::OutDataW-1:0] out_data
);
  import b64d_pkg::*;

  logic [1:0]          idx;
  logic [2:0]          beats;
  logic                final_beat;
  logic                is_data;
  logic                move;
  logic [CharW-1:0]    byte_sel;
  logic [ByteCntW-1:0] total, total_inc, total_next;
  logic [CharW-1:0]    beat_byte;

  assign beats      = {1'b0, head_job.count} + {2'b00, head_job.eod};
  assign final_beat = ({1'b0, idx} == beats - 3'd1);
  assign is_data    = (idx < head_job.count);
  assign move       = head_valid && (!out_valid || out_ready);
  assign pop        = move && final_beat;
  assign total_inc  = (total != ByteMax) ? total + 1'b1 : total;

  always_comb begin
    case (idx)
      2'd0:    byte_sel = head_job.bytes[23:16];
      2'd1:    byte_sel = head_job.bytes[15:8];
      2'd2:    byte_sel = head_job.bytes[7:0];
      default: byte_sel = '0;
    endcase
    beat_byte  = is_data ? byte_sel : '0;
    total_next = is_data ? total_inc : total;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      total     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (move) begin
        out_valid <= 1'b1;
        idx       <= final_beat ? 2'd0 : idx + 1'b1;
        // summary beat ends the buffer and clears the byte count
        total     <= is_data ? total_inc : '0;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      out_kind <= is_data ? KindData : KindSummary;
      out_last <= final_beat;
      out_data <= {7'd0, total_next, head_job.lines, head_job.err, beat_byte};
    end
  end

endmodule

// ===== rtl/core/base64_stream_decoder_core.sv =====
// top level of the base64 stream decoder
`timescale 1ns / 1ps

// streaming base64 decoder, one text character per beat
// input channel s_*: tdata carries the character, tlast marks the last
//   character of a buffer; space and tab are dropped, newline is counted,
//   '=' counts as a pad, anything outside the alphabet sets a sticky error
// output channel m_*: one beat per decoded byte (tuser 0) and, after the last
//   character, one summary beat (tuser 1) with data byte zero; tlast is set
//   on the final beat caused by an input character
// every output beat carries the error flag, newline count and byte count
//   as they stand after that beat; counts saturate
// a completed quad goes into the job queue, then to the output register
// throughput: one character per cycle in while the job queue is not full,
//   one beat per cycle out while jobs wait and the receiver is ready; the back
//   end pops a job only after its final beat
// reset clears the quad state, counts and the four-entry job queue
// a stalled receiver fills the output register and then the job queue; the
//   input keeps taking characters until the queue holds four jobs
module base64_stream_decoder_core
  import b64d_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [CharW-1:0]    s_tdata,   // [7:0] char_code
  input  logic                s_tlast,   // end_of_data
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [OutDataW-1:0] m_tdata,   // [7:0] data_byte, [8] bad_char_seen,
                                         // [24:9] line_count, [48:25] total_bytes
  output logic                m_tuser,   // [0] kind
  output logic                m_tlast    // last
);

  logic push, q_full, pop, head_valid;
  job_t push_job, head_job;

  // front: classification and quad assembly
  b64d_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_char  (s_tdata),
    .in_eod   (s_tlast),
    .in_ready (s_tready),
    .q_full   (q_full),
    .push     (push),
    .push_job (push_job)
  );

  // job queue decouples the character side from the beat side
  b64d_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  // back: beat generation and byte count
  b64d_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_kind   (m_tuser),
    .out_last   (m_tlast),
    .out_data   (m_tdata)
  );

endmodule

// ===== bench/b64d_stream_checker.sv =====
// scoreboard for the base64 stream decoder: predicts output beats and compares them
`timescale 1ns / 1ps

module b64d_stream_checker
  import b64d_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  input  logic                s_tready,
  input  logic [CharW-1:0]    s_tdata,
  input  logic                s_tlast,
  input  logic                m_tvalid,
  input  logic                m_tready,
  input  logic [OutDataW-1:0] m_tdata,
  input  logic                m_tuser,
  input  logic                m_tlast,
  output int                  beats_pending,
  output int                  fail_count
);

  localparam logic [SextetW-1:0] SextetPlus  = 6'd62;
  localparam logic [SextetW-1:0] SextetSlash = 6'd63;

  typedef struct packed {
    logic                kind;
    logic [7:0]          data_byte;
    logic                last;
    logic                bad_char_seen;
    logic [LineW-1:0]    line_count;
    logic [ByteCntW-1:0] total_bytes;
  } decoded_beat_t;

  // decoder state as the block should hold it
  logic [AccW-1:0]     quad_acc;
  logic [1:0]          quad_fill;
  logic [PadW-1:0]     quad_pads;
  logic                bad_seen;
  logic [LineW-1:0]    newline_cnt;
  logic [ByteCntW-1:0] byte_cnt;

  decoded_beat_t due_beats[$];
  decoded_beat_t want;
  int            mismatches;

  // {in alphabet, sextet}
  function automatic logic [SextetW:0] sextet_of(input logic [CharW-1:0] c);
    if (c >= "A" && c <= "Z") return {1'b1, 6'(c - "A")};
    if (c >= "a" && c <= "z") return {1'b1, 6'(c - "a" + 8'd26)};
    if (c >= "0" && c <= "9") return {1'b1, 6'(c - "0" + 8'd52)};
    if (c == "+") return {1'b1, SextetPlus};
    if (c == "/") return {1'b1, SextetSlash};
    return '0;
  endfunction

  task automatic clear_decoder();
    quad_acc    = '0;
    quad_fill   = '0;
    quad_pads   = '0;
    bad_seen    = 1'b0;
    newline_cnt = '0;
    byte_cnt    = '0;
  endtask

  task automatic decode_char(input logic [CharW-1:0] c, input logic eod);
    logic [SextetW:0] lookup;
    logic [SextetW-1:0] v;
    int n_bytes;
    decoded_beat_t beat;
    decoded_beat_t fresh[$];
    if (c == ChSpace || c == ChTab) begin
      // skipped
    end else if (c == ChNewline) begin
      if (newline_cnt != LineMax) newline_cnt++;
    end else begin
      v = '0;
      if (c == ChPad) begin
        if (quad_pads != PadMax) quad_pads++;
      end else begin
        lookup = sextet_of(c);
        v      = lookup[SextetW-1:0];
        if (!lookup[SextetW]) bad_seen = 1'b1;
      end
      quad_acc = {quad_acc[AccW-SextetW-1:0], v};
      if (quad_fill == 2'd3) begin
        n_bytes = (quad_pads == 3'd1) ? 2 : (quad_pads == 3'd2) ? 1 : 3;
        for (int i = 0; i < n_bytes; i++) begin
          if (byte_cnt != ByteMax) byte_cnt++;
          beat.kind          = KindData;
          beat.data_byte     = quad_acc[AccW-1-8*i -: 8];
          beat.last          = 1'b0;
          beat.bad_char_seen = bad_seen;
          beat.line_count    = newline_cnt;
          beat.total_bytes   = byte_cnt;
          fresh.push_back(beat);
        end
        quad_acc  = '0;
        quad_fill = '0;
        quad_pads = '0;
      end else begin
        quad_fill++;
      end
    end
    if (eod) begin
      beat.kind          = KindSummary;
      beat.data_byte     = '0;
      beat.last          = 1'b1;
      beat.bad_char_seen = bad_seen;
      beat.line_count    = newline_cnt;
      beat.total_bytes   = byte_cnt;
      fresh.push_back(beat);
      clear_decoder();
    end else if (fresh.size() > 0) begin
      fresh[fresh.size()-1].last = 1'b1;
    end
    foreach (fresh[i]) due_beats.push_back(fresh[i]);
  endtask

  task automatic compare_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] got_v);
    if (exp_v !== got_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, got_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_decoder();
      due_beats.delete();
    end else begin
      // output first, so a beat can never be matched by a character taken at the same edge
      if (m_tvalid && m_tready) begin
        if (due_beats.size() == 0) begin
          $error("unexpected output beat: tdata 0x%0h tuser %0b tlast %0b",
                 m_tdata, m_tuser, m_tlast);
          mismatches++;
        end else begin
          want = due_beats.pop_front();
          compare_field("kind", want.kind, m_tuser);
          compare_field("data_byte", want.data_byte, m_tdata[7:0]);
          compare_field("last", want.last, m_tlast);
          compare_field("bad_char_seen", want.bad_char_seen, m_tdata[8]);
          compare_field("line_count", want.line_count, m_tdata[24:9]);
          compare_field("total_bytes", want.total_bytes, m_tdata[48:25]);
          compare_field("tdata spare bits", '0, m_tdata[OutDataW-1:49]);
        end
      end
      if (s_tvalid && s_tready) decode_char(s_tdata, s_tlast);
    end
    beats_pending <= due_beats.size();
    fail_count    <= mismatches;
  end

endmodule

// ===== bench/tb_base64_stream_decoder_core.sv =====
// testbench top for the base64 stream decoder: stimulus, stall patterns and verdict
`timescale 1ns / 1ps

module tb_base64_stream_decoder_core;
  import b64d_pkg::*;

  localparam int RandomChars    = 260;   // characters that do real work, spaces/tabs excluded
  localparam int WatchdogLimit  = 2000;  // cycles with no beat moving on either side
  localparam int LongHoldCycles = 80;    // receiver hold-off to back the block up
  localparam int TailCycles     = 10;    // settle time after the last expected beat

  logic                clk;
  logic                rst;
  logic                s_tvalid;
  logic                s_tready;
  logic [CharW-1:0]    s_tdata;   // [7:0] char_code
  logic                s_tlast;   // end_of_data
  logic                m_tvalid;
  logic                m_tready;
  logic [OutDataW-1:0] m_tdata;   // [7:0] data_byte, [8] bad_char_seen,
                                  // [24:9] line_count, [48:25] total_bytes
  logic                m_tuser;   // [0] kind
  logic                m_tlast;

  int beats_pending;
  int fail_count;
  int burst_left;
  int idle_cycles;
  int chars_sent;
  bit hold_off_req;
  bit hold_done;

  base64_stream_decoder_core i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  b64d_stream_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .s_tlast       (s_tlast),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .m_tuser       (m_tuser),
    .m_tlast       (m_tlast),
    .beats_pending (beats_pending),
    .fail_count    (fail_count)
  );

  // 20 ns clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // sextet to its character in the standard alphabet
  function automatic logic [CharW-1:0] alphabet_char(input int unsigned v);
    if (v < 26) return CharW'("A" + v);
    if (v < 52) return CharW'("a" + v - 26);
    if (v < 62) return CharW'("0" + v - 52);
    if (v == 62) return "+";
    return "/";
  endfunction

  // a byte that is neither alphabet, pad nor whitespace
  function automatic logic [CharW-1:0] bad_char();
    case ($urandom_range(0, 3))
      0:       return 8'h00;
      1:       return 8'h0D;   // carriage return
      2:       return CharW'($urandom_range(128, 255));
      default: return "*";
    endcase
  endfunction

  function automatic logic [CharW-1:0] blank_char();
    case ($urandom_range(0, 2))
      0:       return ChSpace;
      1:       return ChTab;
      default: return ChNewline;
    endcase
  endfunction

  // one character beat; the sender runs in bursts with random gaps between them,
  // and valid stays high straight into the next beat within a burst
  task automatic send_char(input logic [CharW-1:0] c, input logic eod);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 8);
      gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      // no gaps while the receiver is held off, so the block has to fill up
      if ((!hold_off_req || hold_done) && gap > 0) begin
        s_tvalid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    s_tvalid = 1'b1;
    s_tdata  = c;
    s_tlast  = eod;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  // stop offering and wait for every predicted beat, then let the pipe settle
  task automatic drain();
    s_tvalid = 1'b0;
    while (beats_pending != 0) @(negedge clk);
    repeat (TailCycles) @(negedge clk);
  endtask

  // mostly well-formed buffers with random content; some noise and broken ones
  task automatic send_random_buffer();
    logic [CharW-1:0] text[$];
    int quads;
    int npad;
    int flavour;
    int len;
    flavour = $urandom_range(0, 9);
    if (flavour == 0) begin
      // pure noise over the whole byte range
      len = $urandom_range(1, 12);
      repeat (len) text.push_back(CharW'($urandom_range(0, 255)));
    end else begin
      quads = ($urandom_range(0, 7) == 0) ? $urandom_range(6, 12) : $urandom_range(0, 4);
      for (int i = 0; i < quads; i++) begin
        npad = 0;
        if (i == quads - 1) begin
          case ($urandom_range(0, 7))
            0, 1:    npad = 1;
            2, 3:    npad = 2;
            4:       npad = $urandom_range(3, 4);   // too many pads, full quad
            default: npad = 0;
          endcase
        end
        for (int j = 0; j < 4; j++) begin
          if ($urandom_range(0, 7) == 0) text.push_back(blank_char());
          if (j >= 4 - npad) text.push_back(ChPad);
          else text.push_back(alphabet_char($urandom_range(0, 63)));
        end
      end
      // a pad out of place now and then
      if ($urandom_range(0, 9) == 0 && text.size() > 0)
        text.insert($urandom_range(0, text.size() - 1), ChPad);
      // trailing partial quad, dropped by the block
      if ($urandom_range(0, 5) == 0)
        repeat ($urandom_range(1, 3)) text.push_back(alphabet_char($urandom_range(0, 63)));
      // broken buffer with a character outside the alphabet
      if (flavour == 1) text.insert($urandom_range(0, text.size()), bad_char());
      // buffer that ends on whitespace
      if ($urandom_range(0, 7) == 0 || text.size() == 0) text.push_back(blank_char());
    end
    foreach (text[i]) begin
      send_char(text[i], i == text.size() - 1);
      if (text[i] != ChSpace && text[i] != ChTab) chars_sent++;
    end
  endtask

  // receiver: changes its stall pattern at random intervals, and on request
  // holds off once for a long stretch counted here
  initial begin : receiver
    int mode;
    int left;
    mode      = 0;
    left      = 0;
    hold_done = 1'b0;
    m_tready  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req && !hold_done) begin
        m_tready = 1'b0;
        repeat (LongHoldCycles - 1) @(negedge clk);
        hold_done = 1'b1;
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 3);
          left = $urandom_range(20, 120);
        end
        left--;
        case (mode)
          0:       m_tready = 1'b1;                           // no stalls
          1:       m_tready = $urandom_range(0, 1);
          2:       m_tready = ($urandom_range(0, 3) == 0);    // mostly stalled
          default: m_tready = (left % 3 == 0);                // ready when left is a multiple of 3
        endcase
      end
    end
  end

  // watchdog: too long with no beat moving anywhere means the block hung
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("** base64_stream_decoder_core: FAILED **");
        $finish;
      end
    end
  end

  initial begin : stimulus
    string head;
    int buf_idx;
    rst          = 1'b1;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    s_tlast      = 1'b0;
    hold_off_req = 1'b0;
    burst_left   = 0;
    chars_sent   = 0;
    repeat (7) @(negedge clk);
    rst = 1'b0;

    // directed: quad split by space and tab, newline inside a quad, two pads,
    // one pad with the top sextet, too many pads, a quad with bad characters at
    // both ends of the byte range, then a partial quad closed by end of data
    head = "TW F\tuQ\nQ==//8==A==";
    for (int i = 0; i < head.len(); i++) send_char(head[i], 1'b0);
    send_char(8'h00, 1'b0);
    send_char(8'hFF, 1'b0);
    send_char(8'h0D, 1'b0);
    send_char("z", 1'b0);
    send_char("9", 1'b0);
    send_char("+", 1'b1);
    drain();

    buf_idx = 0;
    while (chars_sent < RandomChars) begin
      if (buf_idx == 4) hold_off_req = 1'b1;   // back the block up into its queue
      if (buf_idx == 12 || buf_idx == 30) drain();
      send_random_buffer();
      buf_idx++;
    end

    drain();
    if (fail_count == 0) begin
      $display("** base64_stream_decoder_core: PASSED **");
    end else begin
      $display("** base64_stream_decoder_core: FAILED **");
    end
    $finish;
  end

endmodule
